/* sv/vbts_pkg.sv */
// Shared constants, command codes and types of the valid bit table with search.
package vbts_pkg;

	localparam int SLOTS = 256;
	localparam int VALUE_BITS = 32;
	localparam int SLOT_BITS = $clog2(SLOTS);
	localparam int COUNT_BITS = $clog2(SLOTS + 1);

	localparam int CMD_WIDTH = 2;
	localparam int SLOT_WIDTH = 8;
	localparam int VALUE_WIDTH = 32;
	localparam int OCC_WIDTH = 9;

	localparam logic [CMD_WIDTH-1:0] CMD_PUT = 2'd0;
	localparam logic [CMD_WIDTH-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_WIDTH-1:0] CMD_FIND = 2'd2;

	typedef struct packed {
		logic stored;
		logic found;
		logic [SLOT_WIDTH-1:0] found_slot;
		logic [OCC_WIDTH-1:0] occupied;
	} res_t;

	typedef struct packed {
		logic we;
		logic [SLOT_BITS-1:0] waddr;
		logic [VALUE_BITS-1:0] wdata;
		logic re;
		logic [SLOT_BITS-1:0] raddr;
	} ram_req_t;

endpackage

/* sv/valid_bit_table_with_search_top.sv */
// Top level of the valid bit table with search: sequencer and slot value memory.
//
// Channel  Direction  Handshake            Fields
// in       request    in_valid / in_ready   cmd, slot, value
// out      result     out_valid / out_ready stored, found, found_slot, occupied
//
// A put or a delete is done on acceptance; a free output register takes its result.
// A find reads one slot of the value memory per cycle, from slot 0 upward, and ends
// on the first valid match or at the last slot; the single read port of the value
// memory sets this rate.
// Reset clears all valid bits and the occupancy count at once; no clearing pass runs.
// While a result waits in the output register, one more request is taken and its
// result is held until the output register frees.
module valid_bit_table_with_search_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [vbts_pkg::CMD_WIDTH-1:0] cmd,
	input logic [vbts_pkg::SLOT_WIDTH-1:0] slot,
	input logic [vbts_pkg::VALUE_WIDTH-1:0] value,
	output logic out_valid,
	input logic out_ready,
	output logic stored,
	output logic found,
	output logic [vbts_pkg::SLOT_WIDTH-1:0] found_slot,
	output logic [vbts_pkg::OCC_WIDTH-1:0] occupied
);
	import vbts_pkg::*;

	res_t res;
	ram_req_t ram_req;
	logic [VALUE_BITS-1:0] ram_rdata;

	vbts_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.slot(slot),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.res(res),
		.ram_req(ram_req),
		.ram_rdata(ram_rdata)
	);

	vbts_value_ram u_ram (
		.clk(clk),
		.req(ram_req),
		.rdata(ram_rdata)
	);

	assign stored = res.stored;
	assign found = res.found;
	assign found_slot = res.found_slot;
	assign occupied = res.occupied;

endmodule

/* sv/vbts_value_ram.sv */
// Slot value memory with one write port and one registered read port.
module vbts_value_ram (
	input logic clk,
	input vbts_pkg::ram_req_t req,
	output logic [vbts_pkg::VALUE_BITS-1:0] rdata
);
	import vbts_pkg::*;

	logic [VALUE_BITS-1:0] mem_q [SLOTS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem_q[req.raddr];
		end
	end

endmodule

/* sv/vbts_ctrl.sv */
// Command sequencer with valid bits, occupancy count, find scan and result register.
module vbts_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [vbts_pkg::CMD_WIDTH-1:0] cmd,
	input logic [vbts_pkg::SLOT_WIDTH-1:0] slot,
	input logic [vbts_pkg::VALUE_WIDTH-1:0] value,
	output logic out_valid,
	input logic out_ready,
	output vbts_pkg::res_t res,
	output vbts_pkg::ram_req_t ram_req,
	input logic [vbts_pkg::VALUE_BITS-1:0] ram_rdata
);
	import vbts_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_FIND, ST_HOLD} state_t;

	state_t state_q;
	logic [SLOTS-1:0] valid_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [VALUE_BITS-1:0] key_q;
	logic [SLOT_BITS:0] scan_q;
	logic rd_vld_s1;
	logic rd_hit_s1;
	logic [SLOT_BITS-1:0] rd_idx_s1;
	res_t res_q;
	res_t pend_q;
	logic out_valid_q;

	logic accept;
	logic out_free;
	logic [SLOT_BITS-1:0] idx;
	logic in_range;
	logic put_ok;
	logic del_ok;
	logic [COUNT_BITS-1:0] count_nxt;
	logic scan_issue;
	logic match;
	logic last;
	logic find_done;
	logic res_load;
	res_t imm_res;
	res_t find_res;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign idx = SLOT_BITS'(slot);
	assign in_range = 32'(slot) < 32'(SLOTS);
	assign put_ok = (cmd == CMD_PUT) && in_range && !valid_q[idx];
	assign del_ok = (cmd == CMD_DELETE) && in_range && valid_q[idx];

	always_comb begin
		count_nxt = count_q;
		if (put_ok) begin
			count_nxt = count_q + COUNT_BITS'(1);
		end else if (del_ok) begin
			count_nxt = count_q - COUNT_BITS'(1);
		end
	end

	assign scan_issue = (state_q == ST_FIND) && !scan_q[SLOT_BITS];
	assign match = rd_vld_s1 && rd_hit_s1 && (ram_rdata == key_q);
	assign last = rd_vld_s1 && (rd_idx_s1 == SLOT_BITS'(SLOTS - 1));
	assign find_done = (state_q == ST_FIND) && (match || last);
	assign res_load = out_free && (((state_q == ST_IDLE) && accept && (cmd != CMD_FIND))
		|| find_done || (state_q == ST_HOLD));

	always_comb begin
		imm_res.stored = put_ok;
		imm_res.found = 1'b0;
		imm_res.found_slot = '0;
		imm_res.occupied = OCC_WIDTH'(count_nxt);
		find_res.stored = 1'b0;
		find_res.found = match;
		find_res.found_slot = match ? SLOT_WIDTH'(rd_idx_s1) : '0;
		find_res.occupied = OCC_WIDTH'(count_q);
	end

	always_comb begin
		ram_req.we = accept && put_ok;
		ram_req.waddr = idx;
		ram_req.wdata = VALUE_BITS'(value);
		ram_req.re = scan_issue;
		ram_req.raddr = scan_q[SLOT_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_q[SLOT_BITS-1:0];
		rd_hit_s1 <= valid_q[scan_q[SLOT_BITS-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			count_q <= '0;
			scan_q <= '0;
			rd_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= scan_issue && !find_done;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (put_ok) begin
							valid_q[idx] <= 1'b1;
						end
						if (del_ok) begin
							valid_q[idx] <= 1'b0;
						end
						count_q <= count_nxt;
						if (cmd == CMD_FIND) begin
							key_q <= VALUE_BITS'(value);
							scan_q <= '0;
							state_q <= ST_FIND;
						end else if (out_free) begin
							res_q <= imm_res;
						end else begin
							pend_q <= imm_res;
							state_q <= ST_HOLD;
						end
					end
				end
				ST_FIND: begin
					scan_q <= scan_q + (SLOT_BITS + 1)'(1);
					if (find_done) begin
						if (out_free) begin
							res_q <= find_res;
							state_q <= ST_IDLE;
						end else begin
							pend_q <= find_res;
							state_q <= ST_HOLD;
						end
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						res_q <= pend_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign res = res_q;

endmodule

/* sv/vbts_checker.sv */
// Port level checks of the valid bit table with search, bound to the top level.
module vbts_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic stored,
	input logic found,
	input logic [vbts_pkg::SLOT_WIDTH-1:0] found_slot,
	input logic [vbts_pkg::OCC_WIDTH-1:0] occupied
);
	import vbts_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Result was withdrawn before it was taken.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(occupied) && $stable(found_slot))
		else $error("Result changed while it waited.");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(stored && found) && (found || found_slot == '0))
		else $error("Result mixes a put outcome with a find outcome.");

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(occupied) <= 32'(SLOTS))
		else $error("Occupancy exceeds the number of slots.");

	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && out_valid && !out_ready |=> !in_ready)
		else $error("Input stayed open with two requests outstanding.");

endmodule

bind valid_bit_table_with_search_top vbts_checker u_vbts_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.stored(stored),
	.found(found),
	.found_slot(found_slot),
	.occupied(occupied)
);
